[design/mrq_pkg.sv]
package mrq_pkg;

    localparam int TAP_COUNT = 18;
    localparam logic signed [16:0] Q15_0999 = 17'sd32735;

    typedef enum logic [2:0] {
        CFG_DRY_GAIN      = 3'd0,
        CFG_EARLY_GAIN    = 3'd1,
        CFG_REVERB_GAIN   = 3'd2,
        CFG_COMB_FEEDBACK = 3'd3,
        CFG_COMB_WET      = 3'd4,
        CFG_ALLPASS_GAIN  = 3'd5
    } cfg_index_t;

    function automatic logic [12:0] tap_delay(input logic [4:0] i);
        logic [12:0] d;
        begin
            case (i)
                5'd0:  d = 13'd190;
                5'd1:  d = 13'd949;
                5'd2:  d = 13'd993;
                5'd3:  d = 13'd1183;
                5'd4:  d = 13'd1192;
                5'd5:  d = 13'd1315;
                5'd6:  d = 13'd2021;
                5'd7:  d = 13'd2140;
                5'd8:  d = 13'd2524;
                5'd9:  d = 13'd2590;
                5'd10: d = 13'd2625;
                5'd11: d = 13'd2700;
                5'd12: d = 13'd3119;
                5'd13: d = 13'd3123;
                5'd14: d = 13'd3202;
                5'd15: d = 13'd3268;
                5'd16: d = 13'd3321;
                5'd17: d = 13'd3515;
                default: d = 13'd0;
            endcase
            return d;
        end
    endfunction

    function automatic logic signed [16:0] tap_weight(input logic [4:0] i);
        logic signed [16:0] w;
        begin
            case (i)
                5'd0:  w = 17'sd27558;
                5'd1:  w = 17'sd16515;
                5'd2:  w = 17'sd16056;
                5'd3:  w = 17'sd12419;
                5'd4:  w = 17'sd12452;
                5'd5:  w = 17'sd11338;
                5'd6:  w = 17'sd9470;
                5'd7:  w = 17'sd8913;
                5'd8:  w = 17'sd6291;
                5'd9:  w = 17'sd6324;
                5'd10: w = 17'sd7111;
                5'd11: w = 17'sd5931;
                5'd12: w = 17'sd5898;
                5'd13: w = 17'sd5931;
                5'd14: w = 17'sd5767;
                5'd15: w = 17'sd4653;
                5'd16: w = 17'sd5472;
                5'd17: w = 17'sd4391;
                default: w = 17'sd0;
            endcase
            return w;
        end
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
        begin
            if (v > 36'sd32767) begin
                return 16'sh7fff;
            end else if (v < -36'sd32768) begin
                return 16'sh8000;
            end
            return v[15:0];
        end
    endfunction

    function automatic logic signed [15:0] qmul(input logic signed [16:0] a,
                                                input logic signed [16:0] b);
        logic signed [33:0] p;
        begin
            p = a * b;
            return sat16(36'(p >>> 15));
        end
    endfunction

    function automatic logic signed [15:0] qadd(input logic signed [15:0] a,
                                                input logic signed [15:0] b);
        begin
            return sat16(36'(a) + 36'(b));
        end
    endfunction

endpackage

[design/mrq_ram.sv]
module mrq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[design/mrq_front.sv]
module mrq_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [15:0]        s_axis_tdata,
    output logic               q_valid,
    input  logic               q_ready,
    output logic signed [15:0] q_sample
);

    logic               full_reg;
    logic signed [15:0] data_reg;

    assign s_axis_tready = !full_reg || q_ready;
    assign q_valid = full_reg;
    assign q_sample = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg <= 1'b0;
        end else if (s_axis_tready) begin
            full_reg <= s_axis_tvalid;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            data_reg <= s_axis_tdata;
        end
    end

endmodule

[design/mrq_back.sv]
module mrq_back
    import mrq_pkg::*;
#(
    parameter int EARLY_LINE_DEPTH = 4096,
    parameter int COMB_LINE_DEPTH = 4096,
    parameter int ALLPASS_LINE_DEPTH = 512,
    parameter int NUM_COMBS = 6,
    parameter int COMB_DELAY_FIRST_MS = 40,
    parameter int ALLPASS_DELAY_MS = 7
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    output logic               q_ready,
    input  logic signed [15:0] q_sample,
    input  logic [14:0]        dry_gain,
    input  logic [14:0]        early_gain,
    input  logic [14:0]        reverb_gain,
    input  logic [14:0]        comb_feedback,
    input  logic [14:0]        comb_wet,
    input  logic [14:0]        allpass_gain,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [15:0]        m_axis_tdata
);

    localparam int EW = $clog2(EARLY_LINE_DEPTH);
    localparam int CD = NUM_COMBS * COMB_LINE_DEPTH;
    localparam int CW = $clog2(CD);
    localparam int PW = $clog2(COMB_LINE_DEPTH + 1);
    localparam int AW = $clog2(ALLPASS_LINE_DEPTH);
    localparam int KW = (NUM_COMBS > 1) ? $clog2(NUM_COMBS) : 1;
    localparam int AD_RAW = (441 * ALLPASS_DELAY_MS) / 10;
    localparam int AD = (AD_RAW > ALLPASS_LINE_DEPTH) ? ALLPASS_LINE_DEPTH : AD_RAW;
    localparam int CLEAR_N = (CD > EARLY_LINE_DEPTH) ? CD : EARLY_LINE_DEPTH;
    localparam int CLW = $clog2(CLEAR_N + 1);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_TAPRD, ST_TAPACC, ST_COMBRD, ST_COMBMUL,
        ST_COMBWR, ST_APRD, ST_APMUL, ST_APOUT, ST_MIX, ST_OUT
    } state_t;

    state_t state_reg;
    logic [CLW-1:0] clr_reg;
    logic [EW-1:0] eptr_reg;
    logic [AW-1:0] aptr_reg;
    logic [PW-1:0] cptr_reg [NUM_COMBS];
    logic [4:0] tap_reg;
    logic [KW-1:0] k_reg;
    logic signed [15:0] x_reg, early_reg, csum_reg, p_reg, v_reg, ap_reg, y_reg;
    logic signed [15:0] ein_reg, m1_reg, t1_reg, t2_reg;
    logic first_reg;

    logic e_we, c_we, a_we;
    logic [EW-1:0] e_waddr, e_raddr;
    logic [CW-1:0] c_waddr, c_raddr;
    logic [AW-1:0] a_waddr, a_raddr;
    logic [15:0] e_wdata, e_rdata, c_wdata, c_rdata, a_wdata, a_rdata;

    mrq_ram #(.WIDTH(16), .DEPTH(EARLY_LINE_DEPTH)) u_early (
        .aclk(aclk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
        .raddr(e_raddr), .rdata(e_rdata));
    mrq_ram #(.WIDTH(16), .DEPTH(CD)) u_comb (
        .aclk(aclk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
        .raddr(c_raddr), .rdata(c_rdata));
    mrq_ram #(.WIDTH(16), .DEPTH(ALLPASS_LINE_DEPTH)) u_ap (
        .aclk(aclk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
        .raddr(a_raddr), .rdata(a_rdata));

    function automatic logic [PW-1:0] comb_delay(input logic [KW-1:0] k);
        int d;
        begin
            d = (441 * (COMB_DELAY_FIRST_MS + 4 * int'(k))) / 10;
            if (d > COMB_LINE_DEPTH) d = COMB_LINE_DEPTH;
            if (d == 0) d = 1;
            return PW'(d);
        end
    endfunction

    logic [12:0] tdel;
    logic [EW-1:0] tdm;
    logic [PW-1:0] cur_ptr;
    logic signed [16:0] s1;
    logic [CW-1:0] cbase;

    always_comb begin
        tdel = tap_delay(tap_reg);
        tdm = EW'(tdel);
        cur_ptr = cptr_reg[k_reg];
        s1 = Q15_0999 - $signed({2'b0, comb_feedback});
        cbase = CW'(int'(k_reg) * COMB_LINE_DEPTH);
        e_we = (state_reg == ST_CLEAR) || (state_reg == ST_IDLE && q_valid);
        e_waddr = (state_reg == ST_CLEAR) ? clr_reg[EW-1:0] : eptr_reg;
        e_wdata = (state_reg == ST_CLEAR) ? 16'd0 : q_sample;
        e_raddr = (eptr_reg >= tdm) ? eptr_reg - tdm :
                  eptr_reg + EW'(EARLY_LINE_DEPTH) - tdm;
        c_we = (state_reg == ST_CLEAR) || (state_reg == ST_COMBWR);
        c_waddr = (state_reg == ST_CLEAR) ? clr_reg[CW-1:0] : cbase + CW'(cur_ptr);
        c_wdata = (state_reg == ST_CLEAR) ? 16'd0 :
                  qadd(t1_reg, qmul(17'(p_reg), {2'b0, comb_feedback}));
        c_raddr = cbase + CW'(cur_ptr);
        a_we = (state_reg == ST_CLEAR) || (state_reg == ST_APOUT);
        a_waddr = (state_reg == ST_CLEAR) ? clr_reg[AW-1:0] : aptr_reg;
        a_wdata = (state_reg == ST_CLEAR) ? 16'd0 : v_reg;
        a_raddr = aptr_reg;
    end

    assign q_ready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata = y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            eptr_reg <= '0;
            aptr_reg <= '0;
            for (int i = 0; i < NUM_COMBS; i++) cptr_reg[i] <= '0;
        end else begin
            case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == CLW'(CLEAR_N - 1)) state_reg <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (q_valid) begin
                        x_reg <= q_sample;
                        early_reg <= '0;
                        tap_reg <= '0;
                        state_reg <= ST_TAPRD;
                    end
                end
                ST_TAPRD: state_reg <= ST_TAPACC;
                ST_TAPACC: begin
                    early_reg <= qadd(early_reg, qmul(17'($signed(e_rdata)),
                                                      tap_weight(tap_reg)));
                    if (tap_reg == 5'(TAP_COUNT - 1)) begin
                        eptr_reg <= (eptr_reg == EW'(EARLY_LINE_DEPTH - 1)) ?
                                    '0 : eptr_reg + 1'b1;
                        k_reg <= '0;
                        csum_reg <= '0;
                        first_reg <= 1'b1;
                        state_reg <= ST_COMBRD;
                    end else begin
                        tap_reg <= tap_reg + 1'b1;
                        state_reg <= ST_TAPRD;
                    end
                end
                ST_COMBRD: begin
                    if (first_reg) begin
                        ein_reg <= early_reg >>> 3;
                        first_reg <= 1'b0;
                    end
                    state_reg <= ST_COMBMUL;
                end
                ST_COMBMUL: begin
                    p_reg <= c_rdata;
                    m1_reg <= qmul(17'(ein_reg), {2'b0, comb_wet});
                    state_reg <= ST_COMBWR;
                    t1_reg <= '0;
                end
                ST_COMBWR: begin
                    if (t1_reg == 16'sd0 && !first_reg) begin
                        t1_reg <= qmul(17'(m1_reg), s1);
                        first_reg <= 1'b1;
                    end else begin
                        first_reg <= 1'b0;
                        csum_reg <= qadd(csum_reg, p_reg);
                        cptr_reg[k_reg] <= (cur_ptr + 1'b1 == comb_delay(k_reg)) ?
                                           '0 : cur_ptr + 1'b1;
                        if (k_reg == KW'(NUM_COMBS - 1)) begin
                            state_reg <= ST_APRD;
                        end else begin
                            k_reg <= k_reg + 1'b1;
                            state_reg <= ST_COMBRD;
                        end
                    end
                end
                ST_APRD: state_reg <= ST_APMUL;
                ST_APMUL: begin
                    p_reg <= a_rdata;
                    v_reg <= qadd(csum_reg, qmul(17'($signed(a_rdata)),
                                                 {2'b0, allpass_gain}));
                    state_reg <= ST_APOUT;
                end
                ST_APOUT: begin
                    ap_reg <= qadd(qmul(17'(v_reg), -$signed({2'b0, allpass_gain})),
                                   p_reg);
                    aptr_reg <= (aptr_reg == AW'(AD - 1)) ? '0 : aptr_reg + 1'b1;
                    t1_reg <= qmul(17'(x_reg), {2'b0, dry_gain});
                    t2_reg <= qmul({2'b0, early_gain}, 17'(early_reg));
                    state_reg <= ST_MIX;
                end
                ST_MIX: begin
                    y_reg <= qadd(qadd(t1_reg, t2_reg),
                                  qmul({2'b0, reverb_gain}, 17'(ap_reg)));
                    state_reg <= ST_OUT;
                end
                ST_OUT: if (m_axis_tready) state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && !m_axis_tready) |=> state_reg == ST_OUT)
        else $error("result dropped");
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_ready |-> !m_axis_tvalid)
        else $error("accept while result pending");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_APOUT) |=> $past(aptr_reg) != aptr_reg)
        else $error("allpass pointer stuck");

endmodule

[design/moorer_reverb_q15_core.sv]
// Moorer reverberator on signed 16-bit Q15 audio, one output beat per input beat.
// After reset a clearing pass over the larger of NUM_COMBS*COMB_LINE_DEPTH and
// EARLY_LINE_DEPTH addresses (24576 by default) zeroes the delay lines; meanwhile
// only the one beat that the input stage holds is taken. Samples are then worked
// one at a time, paced by the single read port of each delay-line memory that the
// taps and combs go through in turn.
// The input stage holds one beat so the next sample can arrive during work.
module moorer_reverb_q15_core
    import mrq_pkg::*;
#(
    parameter int EARLY_LINE_DEPTH = 4096,
    parameter int COMB_LINE_DEPTH = 4096,
    parameter int ALLPASS_LINE_DEPTH = 512,
    parameter int NUM_COMBS = 6,
    parameter int COMB_DELAY_FIRST_MS = 40,
    parameter int ALLPASS_DELAY_MS = 7
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // sample_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // sample_out
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [14:0] cfg_wdata
);

    logic [14:0] dry_reg, early_reg, reverb_reg, fb_reg, wet_reg, ap_reg;
    logic q_valid, q_ready;
    logic signed [15:0] q_sample;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dry_reg <= 15'd6554;
            early_reg <= 15'd22938;
            reverb_reg <= 15'd26214;
            fb_reg <= 15'd26214;
            wet_reg <= 15'd32735;
            ap_reg <= 15'd16384;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_DRY_GAIN:      dry_reg <= cfg_wdata;
                CFG_EARLY_GAIN:    early_reg <= cfg_wdata;
                CFG_REVERB_GAIN:   reverb_reg <= cfg_wdata;
                CFG_COMB_FEEDBACK: fb_reg <= cfg_wdata;
                CFG_COMB_WET:      wet_reg <= cfg_wdata;
                CFG_ALLPASS_GAIN:  ap_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    mrq_front u_front (
        .aclk(aclk), .aresetn(aresetn), .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
        .q_valid(q_valid), .q_ready(q_ready), .q_sample(q_sample));

    mrq_back #(
        .EARLY_LINE_DEPTH(EARLY_LINE_DEPTH), .COMB_LINE_DEPTH(COMB_LINE_DEPTH),
        .ALLPASS_LINE_DEPTH(ALLPASS_LINE_DEPTH), .NUM_COMBS(NUM_COMBS),
        .COMB_DELAY_FIRST_MS(COMB_DELAY_FIRST_MS), .ALLPASS_DELAY_MS(ALLPASS_DELAY_MS)
    ) u_back (
        .aclk(aclk), .aresetn(aresetn), .q_valid(q_valid), .q_ready(q_ready),
        .q_sample(q_sample), .dry_gain(dry_reg), .early_gain(early_reg),
        .reverb_gain(reverb_reg), .comb_feedback(fb_reg), .comb_wet(wet_reg),
        .allpass_gain(ap_reg), .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata));

endmodule
